@@ rtl/core/escaped_packet_deframer_macros.svh @@
// ---------------------------------------------------------------------------
// Escaped packet deframer assertion macros
// Concurrent assertion helpers. Simulation only; they expand to nothing in
// synthesis.
// ---------------------------------------------------------------------------
`ifndef ESCAPED_PACKET_DEFRAMER_MACROS_SVH
`define ESCAPED_PACKET_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define EPD_ASSERT_IMPLY(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EPD_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |=> (cons)) else $error(msg);

`else

`define EPD_ASSERT_IMPLY(label, clock, resetn, ante, cons, msg)
`define EPD_ASSERT_NEXT(label, clock, resetn, ante, cons, msg)

`endif

`endif

@@ rtl/core/epd_pkg.sv @@
// ---------------------------------------------------------------------------
// Escaped packet deframer package
// Shared widths, byte codes, status codes and the per-word result type.
// ---------------------------------------------------------------------------
package epd_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;

    // Line codes.
    localparam logic [BYTE_W-1:0] END_BYTE      = 8'hFF;
    localparam logic [BYTE_W-1:0] ESC_BYTE      = 8'hFE;
    localparam logic [BYTE_W-1:0] ESC_CODE_FE   = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_CODE_FF   = 8'h01;

    // Raw bytes allowed beyond the payload: length and checksum plus one.
    localparam logic [COUNT_W-1:0] RAW_MARGIN   = 11'd3;

    // Reset value of the maximum payload register.
    localparam logic [COUNT_W-1:0] MAX_PAYLOAD_RESET = 11'd1024;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 3'd0,
        STATUS_TOO_SHORT   = 3'd1,
        STATUS_LEN_MISMATCH = 3'd2,
        STATUS_SUM_MISMATCH = 3'd3,
        STATUS_OVERFLOW    = 3'd4
    } status_t;

    // One result produced by processing a raw byte.
    typedef struct packed {
        logic                 has_result;
        logic [BYTE_W-1:0]    out_byte;
        logic                 is_end;
        status_t              status;
        logic [COUNT_W-1:0]   payload_length;
    } step_result_t;

endpackage

@@ rtl/core/epd_core.sv @@
// ---------------------------------------------------------------------------
// Escaped packet deframer core
// Packet state and the single-pass decode of one raw byte per step.
// ---------------------------------------------------------------------------
module epd_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [epd_pkg::BYTE_W-1:0]    raw_byte,
    input  logic [epd_pkg::COUNT_W-1:0]   raw_limit,
    output epd_pkg::step_result_t         result
);

    import epd_pkg::*;

    logic                  escape_pending_reg, escape_pending_next;
    logic [BYTE_W-1:0]     held0_reg, held0_next;
    logic [BYTE_W-1:0]     held1_reg, held1_next;
    logic [1:0]            held_count_reg, held_count_next;
    logic [COUNT_W-1:0]    payload_count_reg, payload_count_next;
    logic [BYTE_W-1:0]     payload_sum_reg, payload_sum_next;
    logic [COUNT_W-1:0]    raw_count_reg, raw_count_next;

    logic [COUNT_W-1:0]    raw_count_inc;
    logic                  push;
    logic [BYTE_W-1:0]     push_byte;
    logic [BYTE_W-1:0]     check_sum;

    assign raw_count_inc = raw_count_reg + 11'd1;
    assign check_sum     = ~(payload_sum_reg + held0_reg);

    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        held0_next          = held0_reg;
        held1_next          = held1_reg;
        held_count_next     = held_count_reg;
        payload_count_next  = payload_count_reg;
        payload_sum_next    = payload_sum_reg;
        raw_count_next      = raw_count_reg;
        push                = 1'b0;
        push_byte           = raw_byte;
        result              = '0;
        result.status       = STATUS_OK;

        if (step)
        begin
            if (raw_byte == END_BYTE || raw_count_inc >= raw_limit)
            begin
                // End of packet or raw overflow: report and restart.
                result.has_result     = 1'b1;
                result.is_end         = 1'b1;
                result.payload_length = payload_count_reg;
                if (raw_byte != END_BYTE)
                    result.status = STATUS_OVERFLOW;
                else if (held_count_reg != 2'd2)
                    result.status = STATUS_TOO_SHORT;
                else if (payload_count_reg != {3'b000, held0_reg})
                    result.status = STATUS_LEN_MISMATCH;
                else if (held1_reg != check_sum)
                    result.status = STATUS_SUM_MISMATCH;
                else
                    result.status = STATUS_OK;
                escape_pending_next = 1'b0;
                held0_next          = '0;
                held1_next          = '0;
                held_count_next     = '0;
                payload_count_next  = '0;
                payload_sum_next    = '0;
                raw_count_next      = '0;
            end
            else
            begin
                raw_count_next      = raw_count_inc;
                escape_pending_next = 1'b0;
                if (escape_pending_reg && raw_byte == ESC_CODE_FE)
                begin
                    push      = 1'b1;
                    push_byte = ESC_BYTE;
                end
                else if (escape_pending_reg && raw_byte == ESC_CODE_FF)
                begin
                    push      = 1'b1;
                    push_byte = END_BYTE;
                end
                else if (raw_byte == ESC_BYTE)
                begin
                    // A lone escape before another escape is simply dropped.
                    escape_pending_next = 1'b1;
                end
                else
                begin
                    push = 1'b1;
                end
            end

            if (push)
            begin
                if (held_count_reg == 2'd2)
                begin
                    // The oldest held byte is now known to be payload.
                    result.has_result  = 1'b1;
                    result.out_byte    = held0_reg;
                    payload_sum_next   = payload_sum_reg + held0_reg;
                    payload_count_next = payload_count_reg + 11'd1;
                    held0_next         = held1_reg;
                    held1_next         = push_byte;
                end
                else if (held_count_reg == 2'd1)
                begin
                    held1_next      = push_byte;
                    held_count_next = 2'd2;
                end
                else
                begin
                    held0_next      = push_byte;
                    held_count_next = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
            held0_reg          <= '0;
            held1_reg          <= '0;
            held_count_reg     <= '0;
            payload_count_reg  <= '0;
            payload_sum_reg    <= '0;
            raw_count_reg      <= '0;
        end
        else
        begin
            escape_pending_reg <= escape_pending_next;
            held0_reg          <= held0_next;
            held1_reg          <= held1_next;
            held_count_reg     <= held_count_next;
            payload_count_reg  <= payload_count_next;
            payload_sum_reg    <= payload_sum_next;
            raw_count_reg      <= raw_count_next;
        end
    end

endmodule

@@ rtl/core/escaped_packet_deframer.sv @@
// ---------------------------------------------------------------------------
// Escaped packet deframer
// Decodes a byte-stuffed line stream into payload words and one status word
// per packet, checking the trailing length and checksum bytes.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  -------------------------------
//   input     in         in_valid / in_stall    raw_byte
//   output    out        out_valid / out_stall  out_byte, is_end, status,
//                                               payload_length
//   config    in         cfg_wr_en              cfg_wr_data (max payload)
//
// Each accepted word is held in the input register and is decoded from there
// straight into the output register, so one word a cycle is sustained while
// the output does not stall; a result is registered when its word is decoded.
// Reset clears all packet state and loads the maximum payload with 1024.
// A stall on a full output holds both registers; the input keeps taking words
// while its register is empty or being drained in the same cycle.
//
module escaped_packet_deframer
#(
    parameter int PAYLOAD_LIMIT = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [epd_pkg::COUNT_W-1:0]    cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [epd_pkg::BYTE_W-1:0]     raw_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [epd_pkg::BYTE_W-1:0]     out_byte,
    output logic                           is_end,
    output logic [epd_pkg::STATUS_W-1:0]   status,
    output logic [epd_pkg::COUNT_W-1:0]    payload_length
);

    import epd_pkg::*;

    `include "escaped_packet_deframer_macros.svh"

    localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(PAYLOAD_LIMIT);

    // Configuration register.
    logic [COUNT_W-1:0]  max_payload_reg;
    logic [COUNT_W-1:0]  eff_payload;
    logic [COUNT_W-1:0]  raw_limit;

    // Input register.
    logic                in_reg_valid_reg, in_reg_valid_next;
    logic [BYTE_W-1:0]   in_reg_byte_reg;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                is_end_reg;
    status_t             status_reg;
    logic [COUNT_W-1:0]  payload_length_reg;

    logic                out_free;
    logic                step;
    logic                in_accept;
    step_result_t        core_result;

    // Out-of-range settings are clamped: zero behaves as one and anything
    // above the build limit behaves as the limit.
    always_comb
    begin
        if (max_payload_reg == '0)
            eff_payload = 11'd1;
        else if (max_payload_reg > LIMIT)
            eff_payload = LIMIT;
        else
            eff_payload = max_payload_reg;
    end

    assign raw_limit = eff_payload + RAW_MARGIN;

    // The output register can take a new result when it is empty or its
    // current word leaves this cycle. The buffered input word is decoded
    // only then, so a word that yields a result never finds it occupied.
    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = in_reg_valid_reg && out_free;
    assign in_stall  = in_reg_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            in_reg_valid_next = 1'b1;
        else if (step)
            in_reg_valid_next = 1'b0;
        else
            in_reg_valid_next = in_reg_valid_reg;

        if (step && core_result.has_result)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    epd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .raw_byte  (in_reg_byte_reg),
        .raw_limit (raw_limit),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg  <= MAX_PAYLOAD_RESET;
            in_reg_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_payload_reg <= cfg_wr_data;
            in_reg_valid_reg <= in_reg_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_reg_byte_reg <= raw_byte;
        if (step && core_result.has_result)
        begin
            out_byte_reg       <= core_result.out_byte;
            is_end_reg         <= core_result.is_end;
            status_reg         <= core_result.status;
            payload_length_reg <= core_result.payload_length;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign is_end         = is_end_reg;
    assign status         = status_reg;
    assign payload_length = payload_length_reg;

    // A payload word always carries a clear status and a zero length.
    `EPD_ASSERT_IMPLY(a_payload_clean, clk, rst_n, out_valid && !is_end, status == STATUS_OK && payload_length == '0, "payload word with status or length set")

    // No packet can report more payload than the build limit allows.
    `EPD_ASSERT_IMPLY(a_length_bound, clk, rst_n, out_valid && is_end, payload_length <= LIMIT, "reported length above limit")

    // The input is held off only while a buffered word waits for the output.
    `EPD_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, in_reg_valid_reg && out_valid && out_stall, "input stalled without a waiting word")

    // A word decoded into a result must show on the output next cycle.
    `EPD_ASSERT_NEXT(a_result_shown, clk, rst_n, step && core_result.has_result, out_valid, "decoded result not presented")

endmodule
